>>> src/sjisfh_pkg.sv
// Shared types, constants and narrowing tables for the Shift-JIS half-width converter.
package sjisfh_pkg;

	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic [1:0] CFG_KANA  = 2'd0;
	localparam logic [1:0] CFG_ALPHA = 2'd1;
	localparam logic [1:0] CFG_NUM   = 2'd2;

	localparam logic [7:0] LEAD_KANA   = 8'h83;
	localparam logic [7:0] LEAD_PUNCT  = 8'h81;
	localparam logic [7:0] LEAD_ALNUM  = 8'h82;
	localparam logic [7:0] KANA_FIRST  = 8'h40;
	localparam logic [7:0] KANA_LAST   = 8'h96;
	localparam logic [7:0] PUNCT_FIRST = 8'h41;
	localparam logic [7:0] PUNCT_LAST  = 8'h4B;
	localparam logic [7:0] QUOTE_OPEN  = 8'h75;
	localparam logic [7:0] QUOTE_CLOSE = 8'h76;
	localparam logic [7:0] LONG_MARK   = 8'h5B;
	localparam logic [7:0] UPPER_FIRST = 8'h60;
	localparam logic [7:0] UPPER_LAST  = 8'h79;
	localparam logic [7:0] LOWER_FIRST = 8'h81;
	localparam logic [7:0] LOWER_LAST  = 8'h9A;
	localparam logic [7:0] DIGIT_FIRST = 8'h4F;
	localparam logic [7:0] DIGIT_LAST  = 8'h58;

	typedef struct packed {
		logic kana;
		logic alpha;
		logic num;
	} cfg_t;

	// One queued result: one or two bytes, with the end-of-text mark on the final byte.
	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       last;
	} res_entry_t;

	function automatic logic is_lead(input logic [7:0] b);
		return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
	endfunction

	// Zero means pass through, below 0x100 one byte, otherwise two bytes, high byte first.
	function automatic logic [15:0] kana_rom(input logic [6:0] idx);
		logic [15:0] r;
		unique case (idx)
			7'd0: r = 16'h00A7;  7'd1: r = 16'h00B1;  7'd2: r = 16'h00A8;  7'd3: r = 16'h00B2;
			7'd4: r = 16'h00A9;  7'd5: r = 16'h00B3;  7'd6: r = 16'h00AA;  7'd7: r = 16'h00B4;
			7'd8: r = 16'h00AB;  7'd9: r = 16'h00B5;  7'd10: r = 16'h00B6; 7'd11: r = 16'hB6DE;
			7'd12: r = 16'h00B7; 7'd13: r = 16'hB7DE; 7'd14: r = 16'h00B8; 7'd15: r = 16'hB8DE;
			7'd16: r = 16'h00B9; 7'd17: r = 16'hB9DE; 7'd18: r = 16'h00BA; 7'd19: r = 16'hBADE;
			7'd20: r = 16'h00BB; 7'd21: r = 16'hBBDE; 7'd22: r = 16'h00BC; 7'd23: r = 16'hBCDE;
			7'd24: r = 16'h00BD; 7'd25: r = 16'hBDDE; 7'd26: r = 16'h00BE; 7'd27: r = 16'hBEDE;
			7'd28: r = 16'h00BF; 7'd29: r = 16'hBFDE; 7'd30: r = 16'h00C0; 7'd31: r = 16'hC0DE;
			7'd32: r = 16'h00C1; 7'd33: r = 16'hC1DE; 7'd34: r = 16'h00AF; 7'd35: r = 16'h00C2;
			7'd36: r = 16'hC2DE; 7'd37: r = 16'h00C3; 7'd38: r = 16'hC3DE; 7'd39: r = 16'h00C4;
			7'd40: r = 16'hC4DE; 7'd41: r = 16'h00C5; 7'd42: r = 16'h00C6; 7'd43: r = 16'h00C7;
			7'd44: r = 16'h00C8; 7'd45: r = 16'h00C9; 7'd46: r = 16'h00CA; 7'd47: r = 16'hCADE;
			7'd48: r = 16'hCADF; 7'd49: r = 16'h00CB; 7'd50: r = 16'hCBDE; 7'd51: r = 16'hCBDF;
			7'd52: r = 16'h00CC; 7'd53: r = 16'hCCDE; 7'd54: r = 16'hCCDF; 7'd55: r = 16'h00CD;
			7'd56: r = 16'hCDDE; 7'd57: r = 16'hCDDF; 7'd58: r = 16'h00CE; 7'd59: r = 16'hCEDE;
			7'd60: r = 16'hCEDF; 7'd61: r = 16'h00CF; 7'd62: r = 16'h00D0; 7'd63: r = 16'h0000;
			7'd64: r = 16'h00D1; 7'd65: r = 16'h00D2; 7'd66: r = 16'h00D3; 7'd67: r = 16'h00AC;
			7'd68: r = 16'h00D4; 7'd69: r = 16'h00AD; 7'd70: r = 16'h00D5; 7'd71: r = 16'h00AE;
			7'd72: r = 16'h00D6; 7'd73: r = 16'h00D7; 7'd74: r = 16'h00D8; 7'd75: r = 16'h00D9;
			7'd76: r = 16'h00DA; 7'd77: r = 16'h00DB; 7'd78: r = 16'h838E; 7'd79: r = 16'h00DC;
			7'd80: r = 16'h8390; 7'd81: r = 16'h8391; 7'd82: r = 16'h00A6; 7'd83: r = 16'h00DD;
			7'd84: r = 16'hB3DE; 7'd85: r = 16'h8395; 7'd86: r = 16'h8396;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] punct_rom(input logic [3:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd0: r = 8'hA4;  4'd1: r = 8'hA1; 4'd2: r = 8'h2C; 4'd3: r = 8'h2E;
			4'd4: r = 8'hA5;  4'd5: r = 8'h3A; 4'd6: r = 8'h3B; 4'd7: r = 8'h3F;
			4'd8: r = 8'h21;  4'd9: r = 8'hDE; 4'd10: r = 8'hDF;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] map_pair(input cfg_t cfg, input logic [7:0] lead,
			input logic [7:0] trail);
		logic [7:0]  off;
		logic [15:0] r;
		off = 8'h00;
		r   = 16'h0000;
		priority if (cfg.kana && lead == LEAD_KANA && trail >= KANA_FIRST &&
				trail <= KANA_LAST) begin
			off = trail - KANA_FIRST;
			r   = kana_rom(off[6:0]);
		end else if (cfg.kana && lead == LEAD_PUNCT && trail >= PUNCT_FIRST &&
				trail <= PUNCT_LAST) begin
			off = trail - PUNCT_FIRST;
			r   = {8'h00, punct_rom(off[3:0])};
		end else if (cfg.kana && lead == LEAD_PUNCT && trail == QUOTE_OPEN) begin
			r = 16'h00A2;
		end else if (cfg.kana && lead == LEAD_PUNCT && trail == QUOTE_CLOSE) begin
			r = 16'h00A3;
		end else if (cfg.kana && lead == LEAD_PUNCT && trail == LONG_MARK) begin
			r = 16'h00B0;
		end else if (cfg.alpha && lead == LEAD_ALNUM && trail >= UPPER_FIRST &&
				trail <= UPPER_LAST) begin
			r = {8'h00, trail - 8'h1F};
		end else if (cfg.alpha && lead == LEAD_ALNUM && trail >= LOWER_FIRST &&
				trail <= LOWER_LAST) begin
			r = {8'h00, trail - 8'h20};
		end else if (cfg.num && lead == LEAD_ALNUM && trail >= DIGIT_FIRST &&
				trail <= DIGIT_LAST) begin
			r = {8'h00, trail - 8'h1F};
		end else begin
			r = 16'h0000;
		end
		return r;
	endfunction

endpackage

>>> src/sjisfh_front.sv
// Front end: pairs lead and trail bytes and looks up the narrowed result.
module sjisfh_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sjisfh_pkg::cfg_t       cfg,
	input  logic                   accept,
	input  logic [7:0]             in_byte,
	input  logic                   last_in,
	output logic                   push,
	output sjisfh_pkg::res_entry_t entry
);

	logic [7:0]  held_lead_q;
	logic        lead_pending_q;
	logic [15:0] code;

	assign code = sjisfh_pkg::map_pair(cfg, held_lead_q, in_byte);

	always_comb begin
		push  = 1'b0;
		entry = '{two: 1'b0, b0: in_byte, b1: 8'h00, last: last_in};
		if (accept) begin
			priority if (lead_pending_q) begin
				push = 1'b1;
				priority if (code == 16'h0000) begin
					entry = '{two: 1'b1, b0: held_lead_q, b1: in_byte, last: last_in};
				end else if (code[15:8] == 8'h00) begin
					entry = '{two: 1'b0, b0: code[7:0], b1: 8'h00, last: last_in};
				end else begin
					entry = '{two: 1'b1, b0: code[15:8], b1: code[7:0], last: last_in};
				end
			end else if (sjisfh_pkg::is_lead(in_byte) && !last_in) begin
				push = 1'b0;
			end else begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q    <= 8'h00;
			lead_pending_q <= 1'b0;
		end else if (accept) begin
			if (lead_pending_q) begin
				held_lead_q    <= 8'h00;
				lead_pending_q <= 1'b0;
			end else if (sjisfh_pkg::is_lead(in_byte) && !last_in) begin
				held_lead_q    <= in_byte;
				lead_pending_q <= 1'b1;
			end
		end
	end

	// A byte that is only held must not reach the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !lead_pending_q && sjisfh_pkg::is_lead(in_byte) && !last_in |-> !push)
		else $error("held lead byte pushed to the queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && lead_pending_q |=> !lead_pending_q)
		else $error("lead still pending after its trail byte");

endmodule

>>> src/sjisfh_queue.sv
// Short result queue between the front and back ends.
module sjisfh_queue #(
	parameter int Depth = sjisfh_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  sjisfh_pkg::res_entry_t wr_entry,
	input  logic                   pop,
	output sjisfh_pkg::res_entry_t head,
	output logic                   empty,
	output logic                   full
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	sjisfh_pkg::res_entry_t entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == FullCnt);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");

endmodule

>>> src/sjisfh_back.sv
// Back end: sends each queued result one byte at a time through an output register.
module sjisfh_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sjisfh_pkg::res_entry_t head,
	input  logic                   empty,
	output logic                   pop,
	input  logic                   tx_stall,
	output logic                   tx_valid,
	output logic [7:0]             out_byte,
	output logic                   last_out
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       second_q;
	logic       load;

	assign load     = (!valid_q || !tx_stall) && !empty;
	assign pop      = load && (second_q || !head.two);
	assign tx_valid = valid_q;
	assign out_byte = byte_q;
	assign last_out = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= second_q ? head.b1 : head.b0;
			last_q <= (second_q || !head.two) ? head.last : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= head.two && !second_q;
			end else if (!tx_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// The head entry stays in the queue while its second byte is owed.
	assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> !empty)
		else $error("second byte owed but queue is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		load && head.two && !second_q |=> second_q)
		else $error("second byte of a pair skipped");

endmodule

>>> src/sjis_fullwidth_to_halfwidth_unit.sv
// Top level of the Shift-JIS full-width to half-width converter.
// A word that completes a result passes through the queue and the output register to tx.
// The input takes one word per cycle while the queue is not full; a two-byte result leaves
// the single output register a byte at a time, and the queue absorbs the difference.
// A lead byte that is not the last of the text is held and gives no output of its own.
// Reset (arst_n low, asynchronous) clears all modes, any held lead byte and the queue.
module sjis_fullwidth_to_halfwidth_unit #(
	parameter int QueueDepth = sjisfh_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	// Input byte stream
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] in_byte,
	input  logic       last_in,
	// Output byte stream
	output logic       tx_valid,
	input  logic       tx_stall,
	output logic [7:0] out_byte,
	output logic       last_out
);

	sjisfh_pkg::cfg_t       cfg_q;
	sjisfh_pkg::res_entry_t front_entry;
	sjisfh_pkg::res_entry_t head;
	logic                   rx_accept;
	logic                   push;
	logic                   pop;
	logic                   q_empty;
	logic                   q_full;

	// Registers are always writable; write them only while the block is idle (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sjisfh_pkg::CFG_KANA:  cfg_q.kana  <= cfg_data;
				sjisfh_pkg::CFG_ALPHA: cfg_q.alpha <= cfg_data;
				sjisfh_pkg::CFG_NUM:   cfg_q.num   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input is held off only while the queue is full, so a stalled output does not
	// block the stream until every queue slot is taken.
	assign rx_stall  = q_full;
	assign rx_accept = rx_valid && !rx_stall;

	sjisfh_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (rx_accept),
		.in_byte (in_byte),
		.last_in (last_in),
		.push    (push),
		.entry   (front_entry)
	);

	sjisfh_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (front_entry),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	sjisfh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.tx_stall (tx_stall),
		.tx_valid (tx_valid),
		.out_byte (out_byte),
		.last_out (last_out)
	);

endmodule

>>> tb/tb_sjis_fullwidth_to_halfwidth_unit.sv
// Self-checking testbench for the Shift-JIS full-width to half-width converter.
module tb_sjis_fullwidth_to_halfwidth_unit;

	// Index 3 is outside the register list, so a write there must change nothing.
	localparam logic [1:0] CFG_IGNORED = 2'd3;

	// One word on either stream: a text byte and its end-of-text mark.
	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} sjis_word_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = sjisfh_pkg::CFG_KANA;
	logic       cfg_data  = 1'b0;
	logic       rx_valid  = 1'b0;
	logic       rx_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       last_in   = 1'b0;
	logic       tx_valid;
	logic       tx_stall  = 1'b0;
	logic [7:0] out_byte;
	logic       last_out;

	sjis_fullwidth_to_halfwidth_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.in_byte  (in_byte),
		.last_in  (last_in),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.out_byte (out_byte),
		.last_out (last_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Narrowing tables for the katakana block (lead 0x83, trail 0x40 upwards) and for
	// the punctuation run (lead 0x81, trail 0x41 upwards). In the katakana table a zero
	// entry means the pair is left alone, an entry below 0x100 is a single half-width
	// byte and anything larger is two bytes, high byte first.
	logic [15:0] kata_narrow [0:86] = '{
		16'h00A7, 16'h00B1, 16'h00A8, 16'h00B2, 16'h00A9, 16'h00B3, 16'h00AA, 16'h00B4,
		16'h00AB, 16'h00B5, 16'h00B6, 16'hB6DE, 16'h00B7, 16'hB7DE, 16'h00B8, 16'hB8DE,
		16'h00B9, 16'hB9DE, 16'h00BA, 16'hBADE, 16'h00BB, 16'hBBDE, 16'h00BC, 16'hBCDE,
		16'h00BD, 16'hBDDE, 16'h00BE, 16'hBEDE, 16'h00BF, 16'hBFDE, 16'h00C0, 16'hC0DE,
		16'h00C1, 16'hC1DE, 16'h00AF, 16'h00C2, 16'hC2DE, 16'h00C3, 16'hC3DE, 16'h00C4,
		16'hC4DE, 16'h00C5, 16'h00C6, 16'h00C7, 16'h00C8, 16'h00C9, 16'h00CA, 16'hCADE,
		16'hCADF, 16'h00CB, 16'hCBDE, 16'hCBDF, 16'h00CC, 16'hCCDE, 16'hCCDF, 16'h00CD,
		16'hCDDE, 16'hCDDF, 16'h00CE, 16'hCEDE, 16'hCEDF, 16'h00CF, 16'h00D0, 16'h0000,
		16'h00D1, 16'h00D2, 16'h00D3, 16'h00AC, 16'h00D4, 16'h00AD, 16'h00D5, 16'h00AE,
		16'h00D6, 16'h00D7, 16'h00D8, 16'h00D9, 16'h00DA, 16'h00DB, 16'h838E, 16'h00DC,
		16'h8390, 16'h8391, 16'h00A6, 16'h00DD, 16'hB3DE, 16'h8395, 16'h8396
	};
	logic [7:0] punct_narrow [0:10] = '{
		8'hA4, 8'hA1, 8'h2C, 8'h2E, 8'hA5, 8'h3A, 8'h3B, 8'h3F, 8'h21, 8'hDE, 8'hDF
	};

	// The testbench's own copy of the mode registers and of the held lead byte.
	logic       mode_kana  = 1'b0;
	logic       mode_alpha = 1'b0;
	logic       mode_num   = 1'b0;
	logic       lead_held  = 1'b0;
	logic [7:0] held_lead_byte = 8'h00;

	sjis_word_t text_to_send [$];	// words waiting to be offered on rx
	sjis_word_t narrowed_due [$];	// narrowed words not yet seen on tx
	sjis_word_t next_word;
	sjis_word_t due_word;

	int send_idle_pct = 38;
	int recv_idle_pct = 86;
	logic out_hold = 1'b0;
	event hold_go;

	int words_queued = 0;
	int words_in     = 0;
	int words_out    = 0;
	int texts        = 0;
	int reg_writes   = 0;
	int mismatches   = 0;

	function automatic logic starts_pair(input logic [7:0] b);
		return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
	endfunction

	// Looks a two-byte character up under the current modes. Zero means that the
	// pair goes out exactly as it came in.
	function automatic logic [15:0] narrow_code(input logic [7:0] lead,
			input logic [7:0] trail);
		logic [15:0] code;
		code = 16'h0000;
		if (mode_kana && lead == sjisfh_pkg::LEAD_KANA &&
				trail >= sjisfh_pkg::KANA_FIRST && trail <= sjisfh_pkg::KANA_LAST)
			code = kata_narrow[trail - sjisfh_pkg::KANA_FIRST];
		else if (mode_kana && lead == sjisfh_pkg::LEAD_PUNCT &&
				trail >= sjisfh_pkg::PUNCT_FIRST && trail <= sjisfh_pkg::PUNCT_LAST)
			code = {8'h00, punct_narrow[trail - sjisfh_pkg::PUNCT_FIRST]};
		else if (mode_kana && lead == sjisfh_pkg::LEAD_PUNCT &&
				trail == sjisfh_pkg::QUOTE_OPEN)
			code = 16'h00A2;
		else if (mode_kana && lead == sjisfh_pkg::LEAD_PUNCT &&
				trail == sjisfh_pkg::QUOTE_CLOSE)
			code = 16'h00A3;
		else if (mode_kana && lead == sjisfh_pkg::LEAD_PUNCT &&
				trail == sjisfh_pkg::LONG_MARK)
			code = 16'h00B0;
		else if (mode_alpha && lead == sjisfh_pkg::LEAD_ALNUM &&
				trail >= sjisfh_pkg::UPPER_FIRST && trail <= sjisfh_pkg::UPPER_LAST)
			code = {8'h00, 8'h41 + (trail - sjisfh_pkg::UPPER_FIRST)};
		else if (mode_alpha && lead == sjisfh_pkg::LEAD_ALNUM &&
				trail >= sjisfh_pkg::LOWER_FIRST && trail <= sjisfh_pkg::LOWER_LAST)
			code = {8'h00, 8'h61 + (trail - sjisfh_pkg::LOWER_FIRST)};
		else if (mode_num && lead == sjisfh_pkg::LEAD_ALNUM &&
				trail >= sjisfh_pkg::DIGIT_FIRST && trail <= sjisfh_pkg::DIGIT_LAST)
			code = {8'h00, 8'h30 + (trail - sjisfh_pkg::DIGIT_FIRST)};
		return code;
	endfunction

	// Advances the predicted state by one accepted word and queues the words that
	// the converter owes for it: none, one or two.
	function automatic void narrow_word(input logic [7:0] b, input logic fin);
		logic [15:0] code;
		logic [7:0]  lead;
		if (lead_held) begin
			lead           = held_lead_byte;
			code           = narrow_code(lead, b);
			lead_held      = 1'b0;
			held_lead_byte = 8'h00;
			if (code == 16'h0000) begin
				narrowed_due.push_back('{lead, 1'b0});
				narrowed_due.push_back('{b, fin});
			end else if (code < 16'h0100) begin
				narrowed_due.push_back('{code[7:0], fin});
			end else begin
				narrowed_due.push_back('{code[15:8], 1'b0});
				narrowed_due.push_back('{code[7:0], fin});
			end
		end else if (starts_pair(b) && !fin) begin
			lead_held      = 1'b1;
			held_lead_byte = b;
		end else begin
			// Single bytes, and a lead byte that closes the text, go out unchanged.
			narrowed_due.push_back('{b, fin});
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches = mismatches + 1;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// The driver offers the next pending word whenever the current one has gone or
	// none is up. A stalled word is held unchanged until it is taken.
	always @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			narrow_word(in_byte, last_in);
			words_in = words_in + 1;
		end
		if (!rx_valid || !rx_stall) begin
			if (arst_n && text_to_send.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				next_word = text_to_send.pop_front();
				rx_valid <= 1'b1;
				in_byte  <= next_word.code;
				last_in  <= next_word.fin;
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// The monitor checks every word taken from tx against the oldest one owed, and
	// stalls the output at random or for the whole of a long hold-off.
	always @(posedge clk) begin
		if (tx_valid && !tx_stall) begin
			words_out = words_out + 1;
			if (narrowed_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected word %02h last %0b", out_byte, last_out));
			end else begin
				due_word = narrowed_due.pop_front();
				if (out_byte !== due_word.code || last_out !== due_word.fin)
					flag_mismatch($sformatf("word %0d expected %02h last %0b, got %02h last %0b",
						words_out, due_word.code, due_word.fin, out_byte, last_out));
			end
		end
		tx_stall <= out_hold || ($urandom_range(99) < recv_idle_pct);
	end

	// A long output hold-off, counted here, while the sender keeps offering words:
	// the internal queue fills and the converter has to stall its input.
	initial begin
		@(hold_go);
		@(posedge clk);
		out_hold <= 1'b1;
		repeat (64) @(posedge clk);
		out_hold <= 1'b0;
	end

	// A generous ceiling on the whole run; a correct run ends far earlier.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic push_word(input logic [7:0] b, input logic fin);
		text_to_send.push_back('{b, fin});
		words_queued = words_queued + 1;
	endtask

	task automatic push_pair(input logic [7:0] lead, input logic [7:0] trail,
			input logic fin);
		push_word(lead, 1'b0);
		push_word(trail, fin);
	endtask

	function automatic logic [7:0] any_lead();
		if ($urandom_range(1) == 0)
			return 8'($urandom_range(8'h9F, 8'h81));
		return 8'($urandom_range(8'hFC, 8'hE0));
	endfunction

	// One short text made mostly of well-formed characters, with a little noise. A
	// stray byte can be a lead byte that swallows the next one as its trail, and
	// now and then the text ends on a lone lead byte.
	task automatic queue_text();
		int         chars;
		int         c;
		logic       fin_here;
		logic       lone_lead_end;
		logic [7:0] trail;
		chars         = $urandom_range(12, 1);
		lone_lead_end = ($urandom_range(7) == 0);
		for (c = 0; c < chars; c++) begin
			fin_here = (c == chars - 1) && !lone_lead_end;
			case ($urandom_range(9))
				0, 1: push_word(8'($urandom_range(8'h7E, 8'h20)), fin_here);
				2: push_word(8'($urandom_range(8'hDF, 8'hA1)), fin_here);
				3, 4: push_pair(sjisfh_pkg::LEAD_KANA, 8'($urandom_range(8'h98, 8'h3E)),
					fin_here);
				5: begin
					case ($urandom_range(3))
						0: trail = 8'($urandom_range(sjisfh_pkg::PUNCT_LAST,
							sjisfh_pkg::PUNCT_FIRST));
						1: trail = 8'($urandom_range(sjisfh_pkg::QUOTE_CLOSE,
							sjisfh_pkg::QUOTE_OPEN));
						2: trail = sjisfh_pkg::LONG_MARK;
						default: trail = 8'($urandom_range(8'h80, 8'h3F));
					endcase
					push_pair(sjisfh_pkg::LEAD_PUNCT, trail, fin_here);
				end
				6, 7: push_pair(sjisfh_pkg::LEAD_ALNUM, 8'($urandom_range(8'h9C, 8'h4D)),
					fin_here);
				8: push_pair(any_lead(), 8'($urandom_range(255)), fin_here);
				default: push_word(8'($urandom_range(255)), fin_here);
			endcase
		end
		if (lone_lead_end)
			push_word(any_lead(), 1'b1);
		texts = texts + 1;
	endtask

	task automatic queue_words(input int n);
		int target;
		target = words_queued + n;
		while (words_queued < target)
			queue_text();
	endtask

	// Waits until every queued word has been taken and every owed word has been
	// seen, then waits on for anything the converter still has in hand.
	task automatic wait_drained();
		while (words_in != words_queued || narrowed_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sjisfh_pkg::CFG_KANA:  mode_kana  = val;
			sjisfh_pkg::CFG_ALPHA: mode_alpha = val;
			sjisfh_pkg::CFG_NUM:   mode_num   = val;
			default: ;
		endcase
		reg_writes = reg_writes + 1;
	endtask

	// Bit 2 is the kana mode, bit 1 the letter mode and bit 0 the digit mode.
	task automatic set_modes(input logic [2:0] m);
		write_reg(sjisfh_pkg::CFG_KANA, m[2]);
		write_reg(sjisfh_pkg::CFG_ALPHA, m[1]);
		write_reg(sjisfh_pkg::CFG_NUM, m[0]);
	endtask

	initial begin
		logic [2:0] mode_plan [0:11];
		int p;
		int k;
		mode_plan = '{3'b111, 3'b000, 3'b100, 3'b010, 3'b001, 3'b110,
			3'b101, 3'b011, 3'b111, 3'b000, 3'b111, 3'b111};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// With every mode off after reset, and after a write to the unused index,
		// all text must pass through untouched. The text ends on a lone lead byte.
		write_reg(CFG_IGNORED, 1'b1);
		push_word(8'h00, 1'b0);
		push_pair(sjisfh_pkg::LEAD_ALNUM, sjisfh_pkg::UPPER_FIRST, 1'b0);
		push_word(8'hFD, 1'b0);
		push_word(8'hFC, 1'b1);
		wait_drained();

		// Every mode on: each table and range at one of its edges, a zero table entry, a
		// two-byte table entry, a lead byte taken as a trail, and a final pair that
		// narrows to two bytes so that only the second carries the end mark.
		set_modes(3'b111);
		push_pair(sjisfh_pkg::LEAD_KANA, 8'h4B, 1'b0);
		push_pair(sjisfh_pkg::LEAD_KANA, 8'h7F, 1'b0);
		push_pair(sjisfh_pkg::LEAD_KANA, sjisfh_pkg::KANA_LAST, 1'b0);
		push_pair(sjisfh_pkg::LEAD_PUNCT, sjisfh_pkg::PUNCT_LAST, 1'b0);
		push_pair(sjisfh_pkg::LEAD_PUNCT, sjisfh_pkg::QUOTE_OPEN, 1'b0);
		push_pair(sjisfh_pkg::LEAD_PUNCT, sjisfh_pkg::LONG_MARK, 1'b0);
		push_pair(sjisfh_pkg::LEAD_ALNUM, sjisfh_pkg::UPPER_LAST, 1'b0);
		push_pair(sjisfh_pkg::LEAD_ALNUM, sjisfh_pkg::LOWER_FIRST, 1'b0);
		push_pair(sjisfh_pkg::LEAD_ALNUM, sjisfh_pkg::DIGIT_FIRST, 1'b0);
		push_pair(sjisfh_pkg::LEAD_KANA, 8'h4B, 1'b1);
		wait_drained();

		// Random text in three idling profiles, each over four mode settings: a slow
		// receiver, then a slow sender, then both flat out.
		for (p = 0; p < 3; p++) begin
			case (p)
				0: begin send_idle_pct = 38; recv_idle_pct = 86; end
				1: begin send_idle_pct = 86; recv_idle_pct = 38; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (k = 0; k < 4; k++) begin
				set_modes(mode_plan[p * 4 + k]);
				queue_words(50);
				if (p == 2 && k == 0)
					-> hold_go;
				// Here the sender goes quiet until the output has caught up entirely.
				if (p == 1 && k == 2)
					wait_drained();
				queue_words(50);
				wait_drained();
			end
		end

		repeat (16) @(posedge clk);
		if (narrowed_due.size() != 0)
			flag_mismatch($sformatf("%0d words never came out", narrowed_due.size()));

		$display("Run covered %0d words in and %0d words out over %0d texts,",
			words_in, words_out, texts);
		$display("with %0d register writes, a long output hold-off and a full drain.",
			reg_writes);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> sim.f
src/sjisfh_pkg.sv
src/sjisfh_front.sv
src/sjisfh_queue.sv
src/sjisfh_back.sv
src/sjis_fullwidth_to_halfwidth_unit.sv
tb/tb_sjis_fullwidth_to_halfwidth_unit.sv
